// File: rtl/core/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared types, codes and widths of the grid segment collision checker.
// ----------------------------------------------------------------------------
package gscc_pkg;

  localparam int ACT_W   = 2;
  localparam int IDX_W   = 3;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 34;
  localparam int SQ_IN_W = 68;
  localparam int ROOT_W  = 34;
  localparam int PT_W    = 40;
  localparam int K_W     = 64;
  localparam int ACC_W   = 66;
  localparam int FRAC_W  = 30;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POINT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEG   = 2'd2;

  localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESOLUTION  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIZE_X      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIZE_Y      = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAP_PRESENT = 3'd5;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_SQ_X      = 5'd2;
  localparam logic [OP_W-1:0] OP_SQ_Y      = 5'd3;
  localparam logic [OP_W-1:0] OP_SQRT_GO   = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV_STEPS = 5'd5;
  localparam logic [OP_W-1:0] OP_STEPS     = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV_UX    = 5'd7;
  localparam logic [OP_W-1:0] OP_UX        = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV_UY    = 5'd9;
  localparam logic [OP_W-1:0] OP_UY        = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_KX    = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_KY    = 5'd12;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 5'd13;
  localparam logic [OP_W-1:0] OP_POINT     = 5'd14;
  localparam logic [OP_W-1:0] OP_DIV_MX    = 5'd15;
  localparam logic [OP_W-1:0] OP_MX        = 5'd16;
  localparam logic [OP_W-1:0] OP_DIV_MY    = 5'd17;
  localparam logic [OP_W-1:0] OP_MY        = 5'd18;
  localparam logic [OP_W-1:0] OP_RD        = 5'd19;
  localparam logic [OP_W-1:0] OP_ADV       = 5'd20;
  localparam logic [OP_W-1:0] OP_RESULT    = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            col;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             map_on;
    logic             div_done;
    logic             sqrt_done;
    logic             short_seg;
    logic             more;
    logic             pt_bad;
    logic             nb_hit;
    logic             nb_last;
    logic             out_free;
  } stat_t;

endpackage

// File: rtl/core/gscc_div.sv
// ----------------------------------------------------------------------------
// gscc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gscc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gscc_pkg::DVD_W-1:0] dividend,
  input  logic [gscc_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [gscc_pkg::DVD_W-1:0] quotient
);
  import gscc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   r2;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign r2   = {rem_r, q_r[DVD_W-1]};
  assign diff = r2 - {1'b0, dvs_r};
  assign ge   = r2 >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : r2[DVS_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: rtl/core/gscc_sqrt.sv
// ----------------------------------------------------------------------------
// gscc_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module gscc_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gscc_pkg::SQ_IN_W-1:0] radicand,
  output logic                         done,
  output logic [gscc_pkg::ROOT_W-1:0]  root
);
  import gscc_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [SQ_IN_W-1:0] s_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W-1:0]   rem2;
  logic [REM_W-1:0]   trial;
  logic               ge;

  assign rem2  = {rem_r[REM_W-3:0], s_r[SQ_IN_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign ge    = rem2 >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      s_r    <= {s_r[SQ_IN_W-3:0], 2'b00};
      rem_r  <= ge ? rem2 - trial : rem2;
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/core/gscc_dp.sv
// ----------------------------------------------------------------------------
// gscc_dp
// Datapath: configuration, cost grid, arithmetic units and result register.
// ----------------------------------------------------------------------------
module gscc_dp #(
  parameter int MAP_SIDE  = 256,
  parameter int MAX_STEPS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gscc_pkg::cmd_t             cmd,
  output gscc_pkg::stat_t            stat,
  input  logic [1:0]                 in_action,
  input  logic [7:0]                 in_cell_x,
  input  logic [7:0]                 in_cell_y,
  input  logic [7:0]                 in_cell_cost,
  input  logic signed [31:0]         in_start_x,
  input  logic signed [31:0]         in_start_y,
  input  logic signed [31:0]         in_end_x,
  input  logic signed [31:0]         in_end_y,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gscc_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_collides,
  output logic                       out_steps_clipped
);
  import gscc_pkg::*;

  localparam int AW  = $clog2(MAP_SIDE);
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int SZW = ($clog2(MAP_SIDE + 1) > 9) ? $clog2(MAP_SIDE + 1) : 9;

  logic signed [31:0] ox_r, oy_r;
  logic [30:0]        res_r;
  logic [8:0]         szx_r, szy_r;
  logic               map_r;

  logic [ACT_W-1:0]   act_r;
  logic signed [31:0] sx0_r, sy0_r, ex_r, ey_r;
  logic [32:0]        adx_r, ady_r;
  logic               negx_r, negy_r;
  logic [SQ_IN_W-1:0] acc_r;
  logic [SW-1:0]      steps_r, i_r;
  logic               clip_r;
  logic [30:0]        ux_r, uy_r;
  logic [K_W-1:0]     kx_r, ky_r;
  logic [ACC_W-1:0]   pxa_r, pya_r;
  logic signed [PT_W-1:0] px_r, py_r;
  logic               mneg_r;
  logic               badx_r, bady_r;
  logic [AW-1:0]      mx_r, my_r;
  logic [1:0]         nbx_r, nby_r;
  logic               last_r;
  logic [7:0]         rd_r;
  logic               ov_r, ocol_r, oclip_r;

  logic [7:0] mem [2**(2*AW)];

  logic [30:0]        res_e;
  logic [SZW-1:0]     sx_e, sy_e;
  logic signed [32:0] dx, dy;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [31:0]        sq_lo;
  logic               sq_hi;
  logic [SQ_IN_W-1:0] sq;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  seg_len;
  logic signed [PT_W:0] dfx, dfy;
  logic [PT_W:0]      magx, magy;
  logic [ACC_W-FRAC_W-1:0] offx, offy;
  logic               q_bad;
  logic               q_small;
  logic [SZW-1:0]     sz_cur;
  logic [AW+7:0]      wx, wy;
  logic               wr_en;
  logic [AW-1:0]      ax, ay;

  assign res_e = (res_r == '0) ? 31'd1 : res_r;
  assign sx_e  = (SZW'(szx_r) > SZW'(MAP_SIDE)) ? SZW'(MAP_SIDE) : SZW'(szx_r);
  assign sy_e  = (SZW'(szy_r) > SZW'(MAP_SIDE)) ? SZW'(MAP_SIDE) : SZW'(szy_r);

  assign dx = 33'(in_end_x) - 33'(in_start_x);
  assign dy = 33'(in_end_y) - 33'(in_start_y);

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r  <= '0;
      oy_r  <= '0;
      res_r <= 31'd65536;
      szx_r <= 9'd256;
      szy_r <= 9'd256;
      map_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    ox_r  <= cfg_data;
        REG_ORIGIN_Y:    oy_r  <= cfg_data;
        REG_RESOLUTION:  res_r <= cfg_data[30:0];
        REG_SIZE_X:      szx_r <= cfg_data[8:0];
        REG_SIZE_Y:      szy_r <= cfg_data[8:0];
        REG_MAP_PRESENT: map_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = adx_r[31:0];
    mul_b = adx_r[31:0];
    sq_hi = adx_r[32];
    unique case (cmd.op)
      OP_SQ_Y: begin
        mul_a = ady_r[31:0];
        mul_b = ady_r[31:0];
        sq_hi = ady_r[32];
      end
      OP_MUL_KX: begin
        mul_a = 32'(res_e);
        mul_b = 32'(ux_r);
      end
      OP_MUL_KY: begin
        mul_a = 32'(res_e);
        mul_b = 32'(uy_r);
      end
      default: ;
    endcase
  end
  assign prod  = mul_a * mul_b;
  assign sq_lo = mul_a;
  assign sq    = SQ_IN_W'(prod) + (sq_hi ? (SQ_IN_W'({sq_lo, 33'b0}) +
                 (SQ_IN_W'(1) << 64)) : '0);

  // map coordinate prep
  assign dfx  = (PT_W+1)'(px_r) - (PT_W+1)'(ox_r);
  assign dfy  = (PT_W+1)'(py_r) - (PT_W+1)'(oy_r);
  assign magx = dfx[PT_W] ? (PT_W+1)'(-dfx) : (PT_W+1)'(dfx);
  assign magy = dfy[PT_W] ? (PT_W+1)'(-dfy) : (PT_W+1)'(dfy);

  assign div_start = cmd.op == OP_DIV_STEPS || cmd.op == OP_DIV_UX ||
                     cmd.op == OP_DIV_UY || cmd.op == OP_DIV_MX || cmd.op == OP_DIV_MY;

  always_comb begin
    div_dvd = DVD_W'(seg_len);
    div_dvs = DVS_W'(res_e);
    unique case (cmd.op)
      OP_DIV_UX: begin
        div_dvd = DVD_W'({adx_r, 30'b0});
        div_dvs = DVS_W'(seg_len);
      end
      OP_DIV_UY: begin
        div_dvd = DVD_W'({ady_r, 30'b0});
        div_dvs = DVS_W'(seg_len);
      end
      OP_DIV_MX: div_dvd = DVD_W'(magx);
      OP_DIV_MY: div_dvd = DVD_W'(magy);
      default: ;
    endcase
  end

  gscc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  gscc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_SQRT_GO),
    .radicand (acc_r),
    .done     (sqrt_done),
    .root     (seg_len)
  );

  assign offx = pxa_r[ACC_W-1:FRAC_W];
  assign offy = pya_r[ACC_W-1:FRAC_W];

  assign sz_cur  = (cmd.op == OP_MY) ? sy_e : sx_e;
  assign q_small = div_q >= (DVD_W'(sz_cur) - DVD_W'(1));
  assign q_bad   = mneg_r || (div_q == '0) || (sz_cur == '0) || q_small;

  assign ax = mx_r + AW'(nbx_r) - AW'(1);
  assign ay = my_r + AW'(nby_r) - AW'(1);

  assign wx    = (AW+8)'(in_cell_x);
  assign wy    = (AW+8)'(in_cell_y);
  assign wr_en = cmd.op == OP_LOAD && in_action == ACT_WRITE &&
                 32'(in_cell_x) < 32'(MAP_SIDE) && 32'(in_cell_y) < 32'(MAP_SIDE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wy[AW-1:0], wx[AW-1:0]}] <= in_cell_cost;
    end
    if (cmd.op == OP_RD) begin
      rd_r <= mem[{ay, ax}];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act_r  <= in_action;
        sx0_r  <= in_start_x;
        sy0_r  <= in_start_y;
        ex_r   <= in_end_x;
        ey_r   <= in_end_y;
        adx_r  <= dx[32] ? 33'(-dx) : 33'(dx);
        ady_r  <= dy[32] ? 33'(-dy) : 33'(dy);
        negx_r <= dx[32];
        negy_r <= dy[32];
        clip_r <= 1'b0;
      end
      OP_SQ_X: acc_r <= sq;
      OP_SQ_Y: acc_r <= acc_r + sq;
      OP_STEPS: begin
        clip_r  <= div_q > DVD_W'(MAX_STEPS);
        steps_r <= (div_q > DVD_W'(MAX_STEPS)) ? SW'(MAX_STEPS) : div_q[SW-1:0];
      end
      OP_UX: ux_r <= div_q[30:0];
      OP_UY: uy_r <= div_q[30:0];
      OP_MUL_KX: kx_r <= prod;
      OP_MUL_KY: begin
        ky_r  <= prod;
        pxa_r <= ACC_W'(kx_r);
        pya_r <= ACC_W'(prod);
        i_r   <= SW'(1);
      end
      OP_SAMPLE: begin
        px_r <= negx_r ? PT_W'(sx0_r) - PT_W'(offx) : PT_W'(sx0_r) + PT_W'(offx);
        py_r <= negy_r ? PT_W'(sy0_r) - PT_W'(offy) : PT_W'(sy0_r) + PT_W'(offy);
      end
      OP_POINT: begin
        px_r    <= PT_W'(ex_r);
        py_r    <= PT_W'(ey_r);
        steps_r <= '0;
        i_r     <= '0;
      end
      OP_DIV_MX: mneg_r <= dfx[PT_W];
      OP_DIV_MY: mneg_r <= dfy[PT_W];
      OP_MX: begin
        badx_r <= q_bad;
        mx_r   <= div_q[AW-1:0];
      end
      OP_MY: begin
        bady_r <= q_bad;
        my_r   <= div_q[AW-1:0];
        nbx_r  <= 2'd0;
        nby_r  <= 2'd0;
      end
      OP_RD: begin
        last_r <= nbx_r == 2'd2 && nby_r == 2'd2;
        if (nbx_r == 2'd2) begin
          nbx_r <= 2'd0;
          nby_r <= nby_r + 2'd1;
        end else begin
          nbx_r <= nbx_r + 2'd1;
        end
      end
      OP_ADV: begin
        pxa_r <= pxa_r + ACC_W'(kx_r);
        pya_r <= pya_r + ACC_W'(ky_r);
        i_r   <= i_r + SW'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      ocol_r  <= cmd.col;
      oclip_r <= clip_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_collides      = ocol_r;
  assign out_steps_clipped = oclip_r;

  assign stat.action    = act_r;
  assign stat.map_on    = map_r;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.short_seg = seg_len < ROOT_W'(res_e);
  assign stat.more      = i_r < steps_r;
  assign stat.pt_bad    = badx_r || bady_r;
  assign stat.nb_hit    = rd_r != 8'd0;
  assign stat.nb_last   = last_r;
  assign stat.out_free  = !ov_r || !out_stall;

endmodule

// File: rtl/core/gscc_ctl.sv
// ----------------------------------------------------------------------------
// gscc_ctl
// Controller: sequences each item through the datapath operations.
// ----------------------------------------------------------------------------
module gscc_ctl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gscc_pkg::stat_t stat,
  output gscc_pkg::cmd_t  cmd
);
  import gscc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_SQY  = 5'd2;
  localparam logic [4:0] S_SQRT = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_DSTP = 5'd5;
  localparam logic [4:0] S_DUX  = 5'd6;
  localparam logic [4:0] S_DUXW = 5'd7;
  localparam logic [4:0] S_DUY  = 5'd8;
  localparam logic [4:0] S_DUYW = 5'd9;
  localparam logic [4:0] S_MKX  = 5'd10;
  localparam logic [4:0] S_MKY  = 5'd11;
  localparam logic [4:0] S_LOOP = 5'd12;
  localparam logic [4:0] S_DMX  = 5'd13;
  localparam logic [4:0] S_DMXW = 5'd14;
  localparam logic [4:0] S_DMY  = 5'd15;
  localparam logic [4:0] S_DMYW = 5'd16;
  localparam logic [4:0] S_PCHK = 5'd17;
  localparam logic [4:0] S_RD   = 5'd18;
  localparam logic [4:0] S_CHK  = 5'd19;
  localparam logic [4:0] S_RES  = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       col_r, col_nxt;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    cmd.op    = OP_NONE;
    cmd.col   = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.action == ACT_POINT || stat.action == ACT_SEG) begin
          if (!stat.map_on) begin
            col_nxt   = 1'b0;
            state_nxt = S_RES;
          end else if (stat.action == ACT_POINT) begin
            cmd.op    = OP_POINT;
            state_nxt = S_DMX;
          end else begin
            cmd.op    = OP_SQ_X;
            state_nxt = S_SQY;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQY: begin
        cmd.op    = OP_SQ_Y;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op    = OP_SQRT_GO;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (stat.sqrt_done) begin
          if (stat.short_seg) begin
            cmd.op    = OP_POINT;
            state_nxt = S_DMX;
          end else begin
            cmd.op    = OP_DIV_STEPS;
            state_nxt = S_DSTP;
          end
        end
      end
      S_DSTP: begin
        if (stat.div_done) begin
          cmd.op    = OP_STEPS;
          state_nxt = S_DUX;
        end
      end
      S_DUX: begin
        cmd.op    = OP_DIV_UX;
        state_nxt = S_DUXW;
      end
      S_DUXW: begin
        if (stat.div_done) begin
          cmd.op    = OP_UX;
          state_nxt = S_DUY;
        end
      end
      S_DUY: begin
        cmd.op    = OP_DIV_UY;
        state_nxt = S_DUYW;
      end
      S_DUYW: begin
        if (stat.div_done) begin
          cmd.op    = OP_UY;
          state_nxt = S_MKX;
        end
      end
      S_MKX: begin
        cmd.op    = OP_MUL_KX;
        state_nxt = S_MKY;
      end
      S_MKY: begin
        cmd.op    = OP_MUL_KY;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (stat.more) begin
          cmd.op    = OP_SAMPLE;
          state_nxt = S_DMX;
        end else begin
          col_nxt   = 1'b0;
          state_nxt = S_RES;
        end
      end
      S_DMX: begin
        cmd.op    = OP_DIV_MX;
        state_nxt = S_DMXW;
      end
      S_DMXW: begin
        if (stat.div_done) begin
          cmd.op    = OP_MX;
          state_nxt = S_DMY;
        end
      end
      S_DMY: begin
        cmd.op    = OP_DIV_MY;
        state_nxt = S_DMYW;
      end
      S_DMYW: begin
        if (stat.div_done) begin
          cmd.op    = OP_MY;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat.pt_bad) begin
          col_nxt   = 1'b1;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.nb_hit) begin
          col_nxt   = 1'b1;
          state_nxt = S_RES;
        end else if (stat.nb_last) begin
          if (stat.action == ACT_SEG) begin
            cmd.op    = OP_ADV;
            state_nxt = S_LOOP;
          end else begin
            col_nxt   = 1'b0;
            state_nxt = S_RES;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RESULT) |-> stat.out_free)
    else $error("result issued while output register is full");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DISP))
    else $error("accepted beat not dispatched");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMX || state_r == S_DMY) |=> !stat.div_done)
    else $error("divider done not cleared by start");

endmodule

// File: rtl/core/grid_segment_collision_check_unit.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check_unit
// Point and segment collision checker against a stored byte cost grid.
// Cell writes land in the grid at their accept edge. A point query runs two
//   coordinate divisions plus up to nine grid reads, each read followed by a check.
// Segment query: a root, three divisions, then two coordinate divisions and up
//   to nine grid reads per interior sample; one item at a time.
// Reset: configuration returns to defaults; the cost grid is not cleared.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_unit #(
  parameter int MAP_SIDE  = 256,
  parameter int MAX_STEPS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [7:0]         in_cell_cost,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_collides,
  output logic               out_steps_clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gscc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gscc_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gscc_dp #(
    .MAP_SIDE  (MAP_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_action),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_cost      (in_cell_cost),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_collides      (out_collides),
    .out_steps_clipped (out_steps_clipped)
  );

endmodule

// File: verif/gscc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gscc_checker
// Watches the item, result and register channels of the collision checker,
// keeps its own copy of the cost grid and registers, predicts the verdict of
// every point and segment query and compares each result beat in order.
// ----------------------------------------------------------------------------
module gscc_checker #(
  parameter int MAP_SIDE  = 256,
  parameter int MAX_STEPS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  input  logic [7:0]  in_cell_cost,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_collides,
  input  logic        out_steps_clipped,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import gscc_pkg::*;

  typedef struct packed {
    logic hit;
    logic clipped;
  } verdict_t;

  verdict_t verdicts[$];
  logic [7:0] cost_mem [0:MAP_SIDE*MAP_SIDE-1];
  longint org_x, org_y;
  longint unsigned res_reg, sz_x, sz_y;
  bit map_on;

  function automatic longint unsigned eff_res();
    return (res_reg == 0) ? 1 : res_reg;
  endfunction

  function automatic bit point_hit(longint wx, longint wy);
    longint r, sx, sy, mx, my, nx, ny;
    r  = longint'(eff_res());
    sx = (sz_x > MAP_SIDE) ? MAP_SIDE : longint'(sz_x);
    sy = (sz_y > MAP_SIDE) ? MAP_SIDE : longint'(sz_y);
    mx = (wx - org_x) / r;
    my = (wy - org_y) / r;
    if (mx < 0 || my < 0 || mx >= sx || my >= sy) return 1'b1;
    for (int oy = -1; oy <= 1; oy++) begin
      for (int ox = -1; ox <= 1; ox++) begin
        nx = mx + ox;
        ny = my + oy;
        if (nx < 0 || ny < 0 || nx >= sx || ny >= sy) return 1'b1;
        if (cost_mem[ny*MAP_SIDE + nx] != 8'd0) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic longint walk_offset(longint unsigned along, longint unsigned unit,
                                         bit neg);
    logic [127:0] p;
    longint mag;
    p   = {64'd0, along} * {64'd0, unit};
    mag = longint'(p >> 30);
    return neg ? -mag : mag;
  endfunction

  function automatic verdict_t segment_hit(longint x0, longint y0, longint x1, longint y1);
    verdict_t v;
    longint unsigned r, adx, ady, seg_len, steps, ux, uy, cand;
    longint dx, dy, px, py;
    logic [127:0] sum;
    v   = '0;
    r   = eff_res();
    dx  = x1 - x0;
    dy  = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sum = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
    seg_len = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = seg_len | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= sum) seg_len = cand;
    end
    if (seg_len < r) begin
      v.hit = point_hit(x1, y1);
      return v;
    end
    steps = seg_len / r;
    if (steps > MAX_STEPS) begin
      steps     = MAX_STEPS;
      v.clipped = 1'b1;
    end
    ux = (adx << 30) / seg_len;
    uy = (ady << 30) / seg_len;
    for (longint unsigned i = 1; i < steps; i++) begin
      px = x0 + walk_offset(i * r, ux, dx < 0);
      py = y0 + walk_offset(i * r, uy, dy < 0);
      if (point_hit(px, py)) begin
        v.hit = 1'b1;
        return v;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t v, want;
    if (!rst_n) begin
      org_x   = 0;
      org_y   = 0;
      res_reg = 65536;
      sz_x    = 256;
      sz_y    = 256;
      map_on  = 1'b0;
      verdicts.delete();
      errors  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X:    org_x   = longint'(signed'(cfg_data));
          REG_ORIGIN_Y:    org_y   = longint'(signed'(cfg_data));
          REG_RESOLUTION:  res_reg = cfg_data[30:0];
          REG_SIZE_X:      sz_x    = cfg_data[8:0];
          REG_SIZE_Y:      sz_y    = cfg_data[8:0];
          REG_MAP_PRESENT: map_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $error("result beat with no query outstanding");
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (out_collides !== want.hit) begin
            $error("collides: expected %0b actual %0b", want.hit, out_collides);
            errors++;
          end
          if (out_steps_clipped !== want.clipped) begin
            $error("steps_clipped: expected %0b actual %0b", want.clipped,
                   out_steps_clipped);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        v = '0;
        case (in_action)
          ACT_WRITE: cost_mem[in_cell_y*MAP_SIDE + in_cell_x] = in_cell_cost;
          ACT_POINT: begin
            if (map_on) v.hit = point_hit(longint'(signed'(in_end_x)),
                                          longint'(signed'(in_end_y)));
            verdicts.push_back(v);
          end
          ACT_SEG: begin
            if (map_on) v = segment_hit(longint'(signed'(in_start_x)),
                                        longint'(signed'(in_start_y)),
                                        longint'(signed'(in_end_x)),
                                        longint'(signed'(in_end_y)));
            verdicts.push_back(v);
          end
          default: ;
        endcase
      end
    end
    pending = verdicts.size();
  end

endmodule

// File: verif/grid_segment_collision_check_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_segment_collision_check_unit_tb
// Drives cell writes, point queries and segment queries under several
// register settings with random gaps and result back-pressure; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_unit_tb;
  import gscc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_WRITE;
  logic [7:0]  in_cell_x = '0;
  logic [7:0]  in_cell_y = '0;
  logic [7:0]  in_cell_cost = '0;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic signed [31:0] in_end_x = '0;
  logic signed [31:0] in_end_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_collides;
  logic        out_steps_clipped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;

  bit     no_gaps = 1'b0;
  bit     hold_req = 1'b0;
  bit     hold_taken = 1'b0;
  int     stall_cnt = 0;
  int     n_write = 0, n_point = 0, n_seg = 0, n_cfg = 0;
  longint sh_ox = 0, sh_oy = 0, sh_res = 65536, sh_sx = 256, sh_sy = 256;

  always #2 clk = ~clk;

  grid_segment_collision_check_unit DUT (.*);

  gscc_checker CHK (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid && !out_stall) stall_cnt = no_gaps ? 0 : $urandom_range(0, 12);
      else if (stall_cnt > 0) stall_cnt--;
      if (hold_req && !hold_taken) begin
        stall_cnt  = 600;
        hold_taken = 1'b1;
      end
      out_stall <= (stall_cnt > 0);
    end
  end

  task automatic put(logic [1:0] act, logic [7:0] cx, logic [7:0] cy, logic [7:0] cc,
                     logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_cell_x    <= cx;
    in_cell_y    <= cy;
    in_cell_cost <= cc;
    in_start_x   <= sx;
    in_start_y   <= sy;
    in_end_x     <= ex;
    in_end_y     <= ey;
    do @(posedge clk); while (in_stall);
    case (act)
      ACT_WRITE: n_write++;
      ACT_POINT: n_point++;
      ACT_SEG:   n_seg++;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    case (idx)
      REG_ORIGIN_X:   sh_ox  = longint'(signed'(val));
      REG_ORIGIN_Y:   sh_oy  = longint'(signed'(val));
      REG_RESOLUTION: sh_res = (val[30:0] == 0) ? 1 : val[30:0];
      REG_SIZE_X:     sh_sx  = (val[8:0] > 256) ? 256 : val[8:0];
      REG_SIZE_Y:     sh_sy  = (val[8:0] > 256) ? 256 : val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_map(logic [31:0] ox, logic [31:0] oy, logic [31:0] res,
                         logic [31:0] sx, logic [31:0] sy, logic [31:0] on);
    drain();
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_RESOLUTION, res);
    reg_write(REG_SIZE_X, sx);
    reg_write(REG_SIZE_Y, sy);
    reg_write(REG_MAP_PRESENT, on);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] world_at(longint org, longint m);
    return 32'(org + m * sh_res + longint'($urandom_range(0, 32'(sh_res - 1))));
  endfunction

  function automatic logic [7:0] pick_cost();
    return ($urandom_range(0, 99) < 85) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // mx/my land within lim+7 cells of the origin; on a full-size grid keep lim
  // small enough that neighbors stay inside the preloaded corner
  task automatic rand_item(bit wide, int lim);
    int k;
    logic [31:0] sx, sy, ex, ey;
    longint span;
    k    = $urandom_range(0, 99);
    sx   = world_at(sh_ox, $urandom_range(0, lim + 4) - 2);
    sy   = world_at(sh_oy, $urandom_range(0, lim + 4) - 2);
    span = 5 * sh_res;
    ex   = 32'(longint'(signed'(sx)) + longint'($urandom_range(0, 32'(2 * span))) - span);
    ey   = 32'(longint'(signed'(sy)) + longint'($urandom_range(0, 32'(2 * span))) - span);
    if (wide && k % 4 == 0) begin
      sx = $urandom();
      sy = $urandom();
      ex = $urandom();
      ey = $urandom();
    end
    if (k < 20)
      put(ACT_WRITE, $urandom(), $urandom(), pick_cost(), $urandom(), $urandom(),
          $urandom(), $urandom());
    else if (k < 22)
      put(2'd3, $urandom(), $urandom(), $urandom(), sx, sy, ex, ey);
    else if (k < 62 || lim > 40)
      put(ACT_POINT, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), ex, ey);
    else
      put(ACT_SEG, $urandom(), $urandom(), $urandom(), sx, sy, ex, ey);
  endtask

  initial begin
    int lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // preload the corner that small grids use
    no_gaps = 1'b1;
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++)
        put(ACT_WRITE, 8'(x), 8'(y), (x > 4 && y > 4) ? pick_cost() : 8'd0,
            '0, '0, '0, '0);
    no_gaps = 1'b0;
    put(ACT_WRITE, 8'd255, 8'd255, 8'd255, '0, '0, '0, '0);

    set_map(32'd0, 32'd0, 32'd65536, 32'd16, 32'd16, 32'd1);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h0002_8000, 32'h0002_8000);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h0000_0000, 32'h0001_0000);
    put(ACT_SEG, '0, '0, '0, 32'h0002_0000, 32'h0002_0000, 32'h0002_8000, 32'h0002_0000);
    put(ACT_SEG, '0, '0, '0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_8000);
    put(ACT_SEG, '0, '0, '0, 32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_8000);
    put(ACT_SEG, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put(ACT_SEG, '0, '0, '0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    put(2'd3, 8'hFF, 8'hFF, 8'hFF, '1, '1, '1, '1);
    put(ACT_WRITE, 8'd2, 8'd2, 8'd255, '0, '0, '0, '0);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h0002_8000, 32'h0002_8000);
    put(ACT_WRITE, 8'd2, 8'd2, 8'd0, '0, '0, '0, '0);

    // zero resolution with a zero-width grid: everything collides
    set_map(32'hFFFF_FF00, 32'd0, 32'd0, 32'd0, 32'd16, 32'd1);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'd3, 32'd3);
    put(ACT_SEG, '0, '0, '0, 32'd0, 32'd0, 32'd100000, 32'd3);

    // widest cells, origin at the extremes
    set_map(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd16, 32'd1, 32'd1);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h0000_0000, 32'h8000_0000);
    put(ACT_POINT, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h0000_0000);
    put(ACT_SEG, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // no map, oversized register values: all free
    set_map(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd511, 32'd300, 32'd0);
    for (int i = 0; i < 60; i++) rand_item(1'b1, 30);

    // full grid size with queries kept near the preloaded corner
    set_map(32'd0, 32'd0, 32'd65536, 32'd256, 32'd256, 32'd1);
    for (int i = 0; i < 60; i++) rand_item(1'b0, 7);

    // long result hold-off while items keep coming
    hold_req <= 1'b1;
    for (int i = 0; i < 10; i++)
      put(ACT_POINT, '0, '0, '0, '0, '0, world_at(0, 10), world_at(0, 10));

    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 3))
        0: lim = 1;
        1: lim = 16;
        default: lim = $urandom_range(1, 16);
      endcase
      set_map($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
              $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
              (ph == 0) ? 32'd1 : $urandom_range(16, 1 << 20),
              32'(lim), 32'($urandom_range(1, 16)), ($urandom_range(0, 5) != 0));
      no_gaps = (ph == 3);
      for (int i = 0; i < 75; i++) rand_item(1'b1, lim);
    end
    no_gaps = 1'b0;
    drain();

    $display("Covered %0d cell writes, %0d point and %0d segment queries", n_write, n_point,
             n_seg);
    $display("across %0d register writes with random gaps and result hold-off", n_cfg);
    if (errors == 0 && pending == 0) begin
      $display("grid_segment_collision_check_unit test passed");
    end else begin
      $display("grid_segment_collision_check_unit test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("grid_segment_collision_check_unit test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/gscc_pkg.sv
rtl/core/gscc_div.sv
rtl/core/gscc_sqrt.sv
rtl/core/gscc_dp.sv
rtl/core/gscc_ctl.sv
rtl/core/grid_segment_collision_check_unit.sv
verif/gscc_checker.sv
verif/grid_segment_collision_check_unit_tb.sv
